// File: design/apse_pkg.sv
// Shared types and constants for the Annex B parameter-set extractor.
// No dependencies; every other design file imports this package.
`default_nettype none

package apse_pkg;

   localparam int BYTE_W   = 8;
   localparam int TYPE_W   = 5;
   localparam int HOLD_W   = 2;
   localparam int ZCOUNT_W = 3;
   localparam int TCOUNT_W = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [TYPE_W-1:0] KEEP_FIRST_RESET  = 5'd7;
   localparam logic [TYPE_W-1:0] KEEP_SECOND_RESET = 5'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_SECOND = 2'd1;

   localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_ONE  = 8'h01;
   localparam logic [HOLD_W-1:0] HOLD_FULL = 2'd3;

   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   typedef enum logic [3:0] {
      MODE_SEARCH = 4'b0001,
      MODE_HEADER = 4'b0010,
      MODE_KEEP   = 4'b0100,
      MODE_SKIP   = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [BYTE_W-1:0] stream_byte;
      logic              buffer_end;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              run_last;
      logic              extract_end;
   } rsp_payload_type;

   // One burst of results: zero_count zeros, then tail_count tail bytes.
   typedef struct packed {
      logic [ZCOUNT_W-1:0] zero_count;
      logic [TCOUNT_W-1:0] tail_count;
      logic [BYTE_W-1:0]   tail0;
      logic [BYTE_W-1:0]   tail1;
      logic                buf_last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

// File: design/annexb_parameter_set_extractor.sv
// Annex B parameter-set extractor, top level.
// The first result of a byte passes through the command queue and then the output register before it can transfer.
// Throughput: one input byte per cycle while the 4-entry command queue has room;
// results leave at one byte per cycle while rsp_ready is high; a start burst (prefix and header) is 5 bytes.
// Reset (synchronous): keep types 7 and 8, searching for a start code, queue and output empty.
`default_nettype none

module annexb_parameter_set_extractor (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  apse_pkg::req_payload_type        req_payload,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output apse_pkg::rsp_payload_type        rsp_payload,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [apse_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [apse_pkg::TYPE_W-1:0]      csr_data
);
   import apse_pkg::*;

   qstat_type q_stat;
   logic      q_push;
   logic      q_pop;
   cmd_type   push_cmd;
   cmd_type   head_cmd;

   apse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_stat      (q_stat),
      .q_push      (q_push),
      .q_cmd       (push_cmd)
   );

   apse_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .stat     (q_stat)
   );

   apse_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_cmd    (head_cmd),
      .q_stat      (q_stat),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// File: design/apse_front.sv
// Front end: start-code tracking, NAL type filter and config registers.
// Depends on apse_pkg; turns each accepted byte into at most one burst command.
`default_nettype none

module apse_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  apse_pkg::req_payload_type        req_payload,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [apse_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [apse_pkg::TYPE_W-1:0]      csr_data,
   input  apse_pkg::qstat_type              q_stat,
   output logic                             q_push,
   output apse_pkg::cmd_type                q_cmd
);
   import apse_pkg::*;

   logic [TYPE_W-1:0] keep_first_ff, keep_first_in;
   logic [TYPE_W-1:0] keep_second_ff, keep_second_in;
   mode_type          mode_ff, mode_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;

   logic [BYTE_W-1:0] b;
   logic [TYPE_W-1:0] hdr_code;
   logic              accept;
   logic              type_hit;
   mode_type          mode_step;
   logic [HOLD_W-1:0] hold_step;
   cmd_type           cmd;

   assign csr_ready = 1'b1;
   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;
   assign b         = req_payload.stream_byte;
   assign hdr_code  = b[TYPE_W-1:0];
   assign type_hit  = (hdr_code == keep_first_ff) || (hdr_code == keep_second_ff);

   always_comb begin
      keep_first_in  = keep_first_ff;
      keep_second_in = keep_second_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_KEEP_FIRST:  keep_first_in  = csr_data;
            CSR_KEEP_SECOND: keep_second_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      mode_step      = mode_ff;
      hold_step      = hold_ff;
      cmd.zero_count = '0;
      cmd.tail_count = '0;
      cmd.tail0      = b;
      cmd.tail1      = b;
      cmd.buf_last   = req_payload.buffer_end;
      case (mode_ff)
         MODE_HEADER: begin
            hold_step = '0;
            if (type_hit) begin
               cmd.zero_count = 3'd3;
               cmd.tail_count = 2'd2;
               cmd.tail0      = BYTE_ONE;
               mode_step      = MODE_KEEP;
            end else begin
               mode_step = MODE_SKIP;
            end
         end
         MODE_SEARCH, MODE_KEEP, MODE_SKIP: begin
            if (b == BYTE_ONE && hold_ff >= 2'd2) begin
               hold_step = '0;
               mode_step = MODE_HEADER;
            end else if (b == BYTE_ZERO) begin
               // fourth zero in a kept unit: release the oldest one
               if (hold_ff == HOLD_FULL) begin
                  if (mode_ff == MODE_KEEP) cmd.zero_count = 3'd1;
               end else begin
                  hold_step = hold_ff + 2'd1;
               end
            end else begin
               if (mode_ff == MODE_KEEP) begin
                  cmd.zero_count = {1'b0, hold_ff};
                  cmd.tail_count = 2'd1;
               end
               hold_step = '0;
            end
         end
         default: begin
            mode_step = MODE_SEARCH;
            hold_step = '0;
         end
      endcase

      mode_in = mode_step;
      hold_in = hold_step;
      if (req_payload.buffer_end) begin
         // flush held zeros of a kept unit and clear
         if (mode_step == MODE_KEEP)
            cmd.zero_count = cmd.zero_count + {1'b0, hold_step};
         mode_in = MODE_SEARCH;
         hold_in = '0;
      end
   end

   assign q_cmd  = cmd;
   assign q_push = accept && (cmd.zero_count != '0 || cmd.tail_count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_first_ff  <= KEEP_FIRST_RESET;
         keep_second_ff <= KEEP_SECOND_RESET;
         mode_ff        <= MODE_SEARCH;
         hold_ff        <= '0;
      end else begin
         keep_first_ff  <= keep_first_in;
         keep_second_ff <= keep_second_in;
         if (accept) begin
            mode_ff <= mode_in;
            hold_ff <= hold_in;
         end
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.buffer_end |=> mode_ff == MODE_SEARCH && hold_ff == '0)
      else $error("state not cleared after buffer end");

   a_header_no_hold: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_HEADER |-> hold_ff == '0)
      else $error("zeros held while expecting a header");

endmodule

`default_nettype wire

// File: design/apse_queue.sv
// Short command queue between front end and serializer.
// Depends on apse_pkg for the command type and depth.
`default_nettype none

module apse_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  apse_pkg::cmd_type      push_cmd,
   input  wire                    pop,
   output apse_pkg::cmd_type      head_cmd,
   output apse_pkg::qstat_type    stat
);
   import apse_pkg::*;

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;

   assign stat.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: design/apse_back.sv
// Back end: expands queued burst commands into one result byte per cycle while rsp_ready allows.
// Depends on apse_pkg; drives the registered result channel.
`default_nettype none

module apse_back (
   input  wire                          clock,
   input  wire                          reset,
   input  apse_pkg::cmd_type            head_cmd,
   input  apse_pkg::qstat_type          q_stat,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output apse_pkg::rsp_payload_type    rsp_payload
);
   import apse_pkg::*;

   logic [ZCOUNT_W-1:0] idx_ff, idx_in;
   logic                valid_ff, valid_in;
   rsp_payload_type     data_ff, data_in;

   logic [ZCOUNT_W-1:0] total;
   logic [ZCOUNT_W-1:0] tail_idx;
   logic                is_end;
   logic                load;
   logic [BYTE_W-1:0]   elem;

   assign total    = head_cmd.zero_count + {1'b0, head_cmd.tail_count};
   assign tail_idx = idx_ff - head_cmd.zero_count;
   assign is_end   = (idx_ff == total - 3'd1);
   assign load     = !q_stat.empty && (!valid_ff || rsp_ready);
   assign q_pop    = load && is_end;

   always_comb begin
      if (idx_ff < head_cmd.zero_count) elem = BYTE_ZERO;
      else if (tail_idx == '0)          elem = head_cmd.tail0;
      else                              elem = head_cmd.tail1;
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         data_in.out_byte    = elem;
         data_in.run_last    = is_end;
         data_in.extract_end = is_end && head_cmd.buf_last;
         valid_in            = 1'b1;
         idx_in              = is_end ? '0 : idx_ff + 3'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

   a_idx_in_burst: assert property (@(posedge clock) disable iff (reset)
      !q_stat.empty |-> idx_ff < total)
      else $error("burst index past end of command");

endmodule

`default_nettype wire
